### hw/rtl/sscd_pkg.sv
// Package for the sensor scratchpad CRC decode core.
// Holds sequencer states, status codes and frame constants; no dependencies.
package sscd_pkg;

    localparam logic [3:0] FRAME_BYTES = 4'd9;
    localparam logic [7:0] CRC_POLY    = 8'h8C;

    localparam logic [3:0] IDX_TEMP_LOW  = 4'd0;
    localparam logic [3:0] IDX_TEMP_HIGH = 4'd1;
    localparam logic [3:0] IDX_CNT_REM   = 4'd6;
    localparam logic [3:0] IDX_CNT_PER_C = 4'd7;

    localparam logic [3:0] CRC_LAST_BIT = 4'd7;
    localparam logic [3:0] DIV_LAST_BIT = 4'd15;

    localparam logic       REG_SENSOR_MODEL = 1'b0;
    localparam logic       MODEL_12BIT      = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRC,
        S_FIN,
        S_DIV,
        S_SUM
    } t_state;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CRC_ERR  = 2'd1,
        ST_ZERO_CPD = 2'd2
    } t_status;

endpackage

### hw/rtl/sensor_scratchpad_crc_decode_core.sv
// Bytes one to eight each keep busy high while the bit-serial CRC-8 shift unit runs.
// Ninth byte: after the CRC, the decide state sets the result strobe when no divide is needed,
// else 16 restoring-divide steps through one subtractor and then a sum state follow it.
// A start is taken in any cycle in which busy is low; the strobe lasts one cycle, no stall.
// Synchronous active-low reset clears the sequencer, counters, CRC and sensor_model.
// Depends on sscd_pkg.
module sensor_scratchpad_crc_decode_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_temperature,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sscd_pkg::*;

    t_state      r_state, n_state;
    logic [3:0]  r_cnt, n_cnt;
    logic [7:0]  r_crc, n_crc;
    logic [7:0]  r_shift, n_shift;
    logic [3:0]  r_iter, n_iter;
    logic [7:0]  r_tlo, n_tlo;
    logic [7:0]  r_thi, n_thi;
    logic [7:0]  r_crem, n_crem;
    logic [7:0]  r_cpd, n_cpd;
    logic [7:0]  r_rem, n_rem;
    logic [15:0] r_quo, n_quo;
    logic        r_neg, n_neg;
    logic        r_valid, n_valid;
    logic [1:0]  r_status, n_status;
    logic [15:0] r_temp, n_temp;
    logic        r_model;

    logic [3:0]  w_cnt;
    logic        w_fb;
    logic [8:0]  w_trial;
    logic [8:0]  w_diff;
    logic [7:0]  w_mag;
    logic [15:0] w_raw;
    logic [24:0] w_t12;
    logic [24:0] w_q;
    logic [24:0] w_t9;

    function automatic logic [15:0] clamp16(input logic [24:0] v);
        logic [15:0] res;
        if ($signed(v) > $signed(25'd32767)) begin
            res = 16'h7FFF;
        end else if ($signed(v) < -$signed(25'd32768)) begin
            res = 16'h8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    assign busy   = (r_state != S_IDLE);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SENSOR_MODEL) ? {31'd0, r_model} : 32'd0;

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_temperature = r_temp;

    assign w_cnt   = i_frame_start ? 4'd0 : r_cnt;
    assign w_fb    = r_crc[0] ^ r_shift[0];
    assign w_trial = {r_rem, r_quo[15]} - {1'b0, r_cpd};
    assign w_diff  = {1'b0, r_cpd} - {1'b0, r_crem};
    assign w_mag   = w_diff[8] ? 8'(-w_diff) : w_diff[7:0];
    assign w_raw   = {r_thi, r_tlo};
    assign w_t12   = {{5{w_raw[15]}}, w_raw, 4'd0};
    assign w_q     = r_neg ? 25'(-{9'd0, r_quo}) : {9'd0, r_quo};
    assign w_t9    = {{2{w_raw[15]}}, w_raw[15:1], 8'd0} - 25'd64 + w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model <= MODEL_12BIT;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_SENSOR_MODEL) begin
            r_model <= pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= 4'd0;
            r_crc    <= 8'd0;
            r_iter   <= 4'd0;
            r_valid  <= 1'b0;
            r_tlo    <= 8'd0;
            r_thi    <= 8'd0;
            r_crem   <= 8'd0;
            r_cpd    <= 8'd0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_crc    <= n_crc;
            r_iter   <= n_iter;
            r_valid  <= n_valid;
            r_tlo    <= n_tlo;
            r_thi    <= n_thi;
            r_crem   <= n_crem;
            r_cpd    <= n_cpd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift  <= n_shift;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_neg    <= n_neg;
        r_status <= n_status;
        r_temp   <= n_temp;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_crc    = r_crc;
        n_shift  = r_shift;
        n_iter   = r_iter;
        n_tlo    = r_tlo;
        n_thi    = r_thi;
        n_crem   = r_crem;
        n_cpd    = r_cpd;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_neg    = r_neg;
        n_valid  = 1'b0;
        n_status = r_status;
        n_temp   = r_temp;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_shift = i_data_byte;
                    n_iter  = 4'd0;
                    if (i_frame_start) begin
                        n_crc = 8'd0;
                    end
                    case (w_cnt)
                        IDX_TEMP_LOW:  n_tlo  = i_data_byte;
                        IDX_TEMP_HIGH: n_thi  = i_data_byte;
                        IDX_CNT_REM:   n_crem = i_data_byte;
                        IDX_CNT_PER_C: n_cpd  = i_data_byte;
                        default: ;
                    endcase
                    n_cnt   = w_cnt + 4'd1;
                    n_state = S_CRC;
                end
            end
            S_CRC: begin
                n_crc   = (r_crc >> 1) ^ (w_fb ? CRC_POLY : 8'd0);
                n_shift = r_shift >> 1;
                n_iter  = r_iter + 4'd1;
                if (r_iter == CRC_LAST_BIT) begin
                    n_state = (r_cnt == FRAME_BYTES) ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                n_cnt   = 4'd0;
                n_crc   = 8'd0;
                n_state = S_IDLE;
                if (r_crc != 8'd0) begin
                    n_valid  = 1'b1;
                    n_status = ST_CRC_ERR;
                    n_temp   = 16'd0;
                end else if (r_model == MODEL_12BIT) begin
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_temp   = clamp16(w_t12);
                end else if (r_cpd == 8'd0) begin
                    n_valid  = 1'b1;
                    n_status = ST_ZERO_CPD;
                    n_temp   = 16'd0;
                end else begin
                    n_rem   = 8'd0;
                    n_quo   = {w_mag, 8'd0};
                    n_neg   = w_diff[8];
                    n_iter  = 4'd0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!w_trial[8] || r_rem[7]) begin
                    n_rem = w_trial[7:0];
                    n_quo = {r_quo[14:0], 1'b1};
                end else begin
                    n_rem = {r_rem[6:0], r_quo[15]};
                    n_quo = {r_quo[14:0], 1'b0};
                end
                n_iter = r_iter + 4'd1;
                if (r_iter == DIV_LAST_BIT) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_temp   = clamp16(w_t9);
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FRAME_BYTES)
        else $error("byte count past frame length");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_cnt == 4'd0 && r_crc == 8'd0))
        else $error("frame state not cleared with result");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_cpd))
        else $error("divide remainder out of range");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !r_valid))
        else $error("accepted byte did not raise busy");

    a_div_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |=> (r_valid && r_status == ST_OK))
        else $error("divide path result missing");

endmodule
